// File: hdl/ci_pkg.sv
`timescale 1ns / 1ps
package ci_pkg;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_MEAN,
    ST_MEAN_W,
    ST_SQ,
    ST_VAR,
    ST_VAR_W,
    ST_ROOT,
    ST_ROOT_W,
    ST_MUL,
    ST_MARG,
    ST_MARG_W,
    ST_FIN
  } ci_state_t;

  localparam int SAMPLE_W = 32;
  localparam int OUT_W    = 31;
  localparam int T_W      = 18;
  localparam int LEVEL_W  = 3;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 3'd4;
  localparam logic [OUT_W-1:0]   OUT_SAT   = {OUT_W{1'b1}};

  // Student t values in unsigned Q2.16, by level code
  function automatic logic [T_W-1:0] t_value(input logic [LEVEL_W-1:0] lvl);
    logic [T_W-1:0] t;
    unique case (lvl)
      3'd0:    t = 18'd193135;
      3'd1:    t = 18'd170525;
      3'd2:    t = 18'd139657;
      3'd3:    t = 18'd114885;
      3'd4:    t = 18'd99418;
      default: t = '0;
    endcase
    return t;
  endfunction

  // integer square root for elaboration-time constants
  function automatic logic [63:0] isqrt_const(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    logic [63:0] rem;
    res  = '0;
    bitv = 64'd1 << 62;
    rem  = v;
    for (int i = 0; i < 32; i++) begin
      if (bitv != 0) begin
        if (rem >= res + bitv) begin
          rem = rem - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
    end
    return res;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -34'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// File: hdl/ci_div.sv
`timescale 1ns / 1ps
module ci_div import ci_pkg::*; #(
  parameter int NUM_W = 67,
  parameter int DEN_W = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CW = $clog2(NUM_W);

  logic [NUM_W-1:0] quo_sh;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;
  logic [DEN_W-1:0] rem_next;

  always_comb begin
    trial    = {rem, quo_sh[NUM_W-1]};
    diff     = trial - {1'b0, den_r};
    ge       = trial >= {1'b0, den_r};
    rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      quo_sh <= num;
      rem    <= '0;
      den_r  <= den;
    end else if (busy) begin
      quo_sh <= {quo_sh[NUM_W-2:0], ge};
      rem    <= rem_next;
    end
  end

  assign quo = quo_sh;

endmodule

// File: hdl/ci_sqrt.sv
`timescale 1ns / 1ps
module ci_sqrt import ci_pkg::*; #(
  parameter int RW = 31
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [2*RW-1:0] val,
  output logic            done,
  output logic [RW-1:0]   root
);

  localparam int CW = $clog2(RW);

  logic [2*RW-1:0] val_sh;
  logic [RW:0]     rem;
  logic [CW-1:0]   cnt;
  logic            busy;
  logic [RW+2:0]   rem_sh;
  logic [RW+2:0]   trial;
  logic [RW+2:0]   diff;
  logic            ge;

  always_comb begin
    rem_sh = {rem, val_sh[2*RW-1 -: 2]};
    trial  = {1'b0, root, 2'b01};
    diff   = rem_sh - trial;
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(RW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // two radicand bits in, one root bit out per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      val_sh <= val;
      rem    <= '0;
      root   <= '0;
    end else if (busy) begin
      val_sh <= {val_sh[2*RW-3:0], 2'b00};
      rem    <= ge ? diff[RW:0] : rem_sh[RW:0];
      root   <= {root[RW-2:0], ge};
    end
  end

endmodule

// File: hdl/t_confidence_interval.sv
`timescale 1ns / 1ps
// SAMPLE_COUNT samples load one per cycle while sample_stall is low. After the last one,
// result_valid rises once the bit-serial divider (DIV_W steps each for mean, variance and
// margin) and the root have run. An invalid level skips the margin division; a saturated
// deviation skips the root. Throughput: one result per batch; samples stall meanwhile.
// Reset (rst, synchronous): clears state, sample count, running sum, level and valid flag.
module t_confidence_interval import ci_pkg::*; #(
  parameter int SAMPLE_COUNT = 15
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       sample_valid,
  output logic                       sample_stall,
  input  logic signed [SAMPLE_W-1:0] sample_value,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [LEVEL_W-1:0]         cfg_data,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic signed [31:0]         interval_low,
  output logic signed [31:0]         interval_high,
  output logic signed [31:0]         mean_value,
  output logic [OUT_W-1:0]           std_deviation,
  output logic [OUT_W-1:0]           error_margin,
  output logic                       bad_level
);

  localparam int CNT_W  = $clog2(SAMPLE_COUNT);
  localparam int SUM_W  = SAMPLE_W + $clog2(SAMPLE_COUNT);
  localparam int ACC_W  = 66 + $clog2(SAMPLE_COUNT);
  localparam int DIV_W  = ACC_W;
  localparam int DEN_W  = 32;
  localparam int MP_W   = T_W + OUT_W;
  localparam logic [63:0] ROOT_N = isqrt_const(64'(SAMPLE_COUNT) << 32);

  ci_state_t state, state_next;

  logic [LEVEL_W-1:0]         level;
  logic [LEVEL_W-1:0]         lvl;
  logic [CNT_W-1:0]           count;
  logic signed [SUM_W-1:0]    sum;
  logic signed [SAMPLE_W-1:0] mem [SAMPLE_COUNT];
  logic signed [SAMPLE_W-1:0] rd_data;
  logic [CNT_W-1:0]           idx;
  logic [2:0]                 ph;
  logic signed [31:0]         mean;
  logic [32:0]                mag;
  logic [33:0]                prod;
  logic [ACC_W-1:0]           acc;
  logic [OUT_W-1:0]           stdv;
  logic [MP_W-1:0]            mprod;
  logic [OUT_W-1:0]           margin;
  logic                       bad;

  logic                       in_acc;
  logic                       last_in;
  logic                       div_start, div_done, sqrt_start, sqrt_done;
  logic [DIV_W-1:0]           div_num, div_quo;
  logic [DEN_W-1:0]           div_den;
  logic [OUT_W-1:0]           sqrt_root;
  logic                       var_big;
  logic [SUM_W-1:0]           abs_sum;
  logic signed [33:0]         diff;
  logic [16:0]                mul_a, mul_b;
  logic                       sq_last;
  logic                       out_load;
  logic signed [33:0]         lo_w, hi_w;

  assign cfg_ready = 1'b1;
  assign in_acc    = sample_valid && !sample_stall;
  assign last_in   = in_acc && (count == CNT_W'(SAMPLE_COUNT - 1));
  assign var_big   = |div_quo[DIV_W-1:62];
  assign sq_last   = (ph == 3'd5) && (idx == CNT_W'(SAMPLE_COUNT - 1));
  assign out_load  = (state == ST_FIN) && (!result_valid || !result_stall);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD:   if (last_in) state_next = ST_MEAN;
      ST_MEAN:   state_next = ST_MEAN_W;
      ST_MEAN_W: if (div_done) state_next = ST_SQ;
      ST_SQ:     if (sq_last) state_next = ST_VAR;
      ST_VAR:    state_next = ST_VAR_W;
      ST_VAR_W: begin
        if (div_done) state_next = var_big ? ST_MUL : ST_ROOT;
      end
      ST_ROOT:   state_next = ST_ROOT_W;
      ST_ROOT_W: if (sqrt_done) state_next = ST_MUL;
      ST_MUL:    state_next = bad ? ST_FIN : ST_MARG;
      ST_MARG:   state_next = ST_MARG_W;
      ST_MARG_W: if (div_done) state_next = ST_FIN;
      ST_FIN:    if (out_load) state_next = ST_LOAD;
      default:   state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    sample_stall = (state != ST_LOAD);
    div_start    = (state == ST_MEAN) || (state == ST_VAR) || (state == ST_MARG);
    sqrt_start   = (state == ST_ROOT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_LOAD;
      level        <= '0;
      count        <= '0;
      sum          <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) level <= cfg_data;
      if (in_acc) begin
        sum   <= sum + SUM_W'(sample_value);
        count <= last_in ? '0 : count + 1'b1;
      end
      if (out_load) begin
        sum          <= '0;
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // sample store: one write port, registered read
  always_ff @(posedge clk) begin
    if (in_acc) mem[count] <= sample_value;
    rd_data <= mem[idx];
  end

  always_comb begin
    abs_sum = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    diff    = 34'(rd_data) - 34'(mean);
    unique case (ph)
      3'd2:    begin mul_a = {1'b0, mag[15:0]}; mul_b = {1'b0, mag[15:0]}; end
      3'd3:    begin mul_a = mag[32:16];        mul_b = {1'b0, mag[15:0]}; end
      default: begin mul_a = mag[32:16];        mul_b = mag[32:16];        end
    endcase
    priority case (state)
      ST_MEAN: begin
        div_num = DIV_W'(abs_sum) + DIV_W'(SAMPLE_COUNT / 2);
        div_den = DEN_W'(SAMPLE_COUNT);
      end
      ST_VAR: begin
        div_num = acc;
        div_den = DEN_W'(SAMPLE_COUNT - 1);
      end
      default: begin
        div_num = DIV_W'(mprod) + DIV_W'(ROOT_N >> 1);
        div_den = DEN_W'(ROOT_N);
      end
    endcase
    lo_w = 34'(mean) - 34'(margin);
    hi_w = 34'(mean) + 34'(margin);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph  <= '0;
      idx <= '0;
    end else if (state == ST_SQ) begin
      if (ph == 3'd5) begin
        ph  <= '0;
        idx <= sq_last ? '0 : idx + 1'b1;
      end else begin
        ph <= ph + 1'b1;
      end
    end
  end

  // datapath: mean, sum of squares in three partial products per entry, deviation, margin, outputs
  always_ff @(posedge clk) begin
    if (last_in) lvl <= level;
    if (state == ST_MEAN) bad <= lvl > LEVEL_MAX;
    if (state == ST_MEAN_W && div_done) begin
      mean <= sum[SUM_W-1] ? -div_quo[31:0] : div_quo[31:0];
      acc  <= '0;
    end
    if (state == ST_SQ) begin
      unique case (ph)
        3'd1: mag <= diff[33] ? 33'(-diff) : diff[32:0];
        3'd3: acc <= acc + ACC_W'(prod);
        3'd4: acc <= acc + (ACC_W'(prod) << 17);
        3'd5: acc <= acc + (ACC_W'(prod) << 32);
        default: ;
      endcase
      prod <= mul_a * mul_b;
    end
    if (state == ST_VAR_W && div_done && var_big) stdv <= OUT_SAT;
    if (state == ST_ROOT_W && sqrt_done) stdv <= sqrt_root;
    if (state == ST_MUL) begin
      mprod <= t_value(lvl) * stdv;
      if (bad) margin <= '0;
    end
    if (state == ST_MARG_W && div_done) begin
      margin <= (|div_quo[DIV_W-1:OUT_W]) ? OUT_SAT : div_quo[OUT_W-1:0];
    end
    if (out_load) begin
      mean_value    <= mean;
      std_deviation <= stdv;
      error_margin  <= margin;
      bad_level     <= bad;
      interval_low  <= bad ? 32'sd0 : sat32(lo_w);
      interval_high <= bad ? 32'sd0 : sat32(hi_w);
    end
  end

  ci_div #(.NUM_W(DIV_W), .DEN_W(DEN_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  ci_sqrt #(.RW(OUT_W)) u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .val   (div_quo[2*OUT_W-1:0]),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

endmodule

// File: dv/tb_t_confidence_interval.sv
`timescale 1ns / 1ps
module tb_t_confidence_interval;
  import ci_pkg::*;

  localparam int BATCH      = 15;
  localparam int DRAIN_WAIT = 400;
  localparam int HOLD_OFF   = 3000;
  localparam int N_PHASES   = 9;
  localparam int BATCHES_PER_PHASE = 4;

  // Student t in unsigned Q2.16 per level code
  localparam logic [17:0] T99 = 18'd193135;
  localparam logic [17:0] T98 = 18'd170525;
  localparam logic [17:0] T95 = 18'd139657;
  localparam logic [17:0] T90 = 18'd114885;
  localparam logic [17:0] T85 = 18'd99418;

  typedef enum int {MIX_FULL, MIX_CLUSTER, MIX_EXTREME, MIX_FLAT} batch_mix_t;

  typedef struct packed {
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic signed [31:0] mean;
    logic [OUT_W-1:0]   sd;
    logic [OUT_W-1:0]   margin;
    logic               bad;
  } ci_result_t;

  typedef struct {
    logic signed [31:0] x;
    bit                 typed;
    ci_result_t         res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sample_valid = 1'b0;
  logic sample_stall;
  logic signed [SAMPLE_W-1:0] sample_value = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [LEVEL_W-1:0] cfg_data = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic signed [31:0] interval_low, interval_high, mean_value;
  logic [OUT_W-1:0] std_deviation, error_margin;
  logic bad_level;

  t_confidence_interval uut (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_stall(sample_stall), .sample_value(sample_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .result_valid(result_valid), .result_stall(result_stall),
    .interval_low(interval_low), .interval_high(interval_high), .mean_value(mean_value),
    .std_deviation(std_deviation), .error_margin(error_margin), .bad_level(bad_level)
  );

  always #5 clk = ~clk;

  ci_result_t pending_results[$];
  logic signed [31:0] batch_samples[BATCH];
  int batch_fill = 0;
  longint batch_sum = 0;
  logic [LEVEL_W-1:0] level_reg = '0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  int failures = 0;
  int results_checked = 0;
  int samples_sent = 0;
  int bad_batches = 0;
  stim_row_t stim_table[2*BATCH];

  function automatic logic [31:0] int_sqrt(input logic [63:0] v);
    logic [31:0] root;
    logic [31:0] trial;
    root = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (32'd1 << i);
      if (64'(trial) * 64'(trial) <= v) root = trial;
    end
    return root;
  endfunction

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic [17:0] t_for_level(input logic [LEVEL_W-1:0] lvl);
    case (lvl)
      3'd0: return T99;
      3'd1: return T98;
      3'd2: return T95;
      3'd3: return T90;
      default: return T85;
    endcase
  endfunction

  function automatic ci_result_t interval_of_batch();
    ci_result_t r;
    longint mean;
    longint diff;
    logic [63:0] mag;
    logic [127:0] sumsq;
    logic [127:0] var_q;
    logic [63:0] sd;
    logic [63:0] root;
    logic [63:0] prod;
    logic [63:0] margin;
    if (batch_sum >= 0) mean = (batch_sum + BATCH / 2) / BATCH;
    else mean = -((-batch_sum + BATCH / 2) / BATCH);
    sumsq = '0;
    for (int i = 0; i < BATCH; i++) begin
      diff = longint'(batch_samples[i]) - mean;
      mag = (diff < 0) ? 64'(-diff) : 64'(diff);
      sumsq += 128'(mag) * 128'(mag);
    end
    var_q = sumsq / (BATCH - 1);
    if (var_q >= (128'd1 << 62)) sd = 64'h7FFFFFFF;
    else sd = 64'(int_sqrt(var_q[63:0]));
    r.mean = mean[31:0];
    r.sd = sd[OUT_W-1:0];
    r.bad = (level_reg > LEVEL_MAX);
    if (r.bad) begin
      r.margin = '0;
      r.lo = '0;
      r.hi = '0;
    end else begin
      root = 64'(int_sqrt(64'(BATCH) << 32));
      prod = 64'(t_for_level(level_reg)) * sd;
      margin = (prod + root / 2) / root;
      if (margin > 64'h7FFFFFFF) margin = 64'h7FFFFFFF;
      r.margin = margin[OUT_W-1:0];
      r.lo = clamp32(mean - longint'(margin));
      r.hi = clamp32(mean + longint'(margin));
    end
    return r;
  endfunction

  // fold one accepted sample into the batch; on the last one queue the result
  task automatic absorb_sample(input logic signed [31:0] x, input bit typed,
                               input ci_result_t typed_res);
    batch_samples[batch_fill] = x;
    batch_sum += longint'(x);
    batch_fill++;
    samples_sent++;
    if (batch_fill == BATCH) begin
      if (level_reg > LEVEL_MAX) bad_batches++;
      pending_results.push_back(typed ? typed_res : interval_of_batch());
      batch_fill = 0;
      batch_sum = 0;
    end
  endtask

  task automatic send_sample(input logic signed [31:0] x, input bit typed,
                             input ci_result_t typed_res);
    if (!calm && $urandom_range(99) < 11) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample_value <= x;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    absorb_sample(x, typed, typed_res);
  endtask

  task automatic wait_idle();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_level(input logic [LEVEL_W-1:0] lvl);
    cfg_valid <= 1'b1;
    cfg_data <= lvl;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    level_reg = lvl;
  endtask

  function automatic logic signed [31:0] pick_sample(input batch_mix_t mix,
                                                     input logic signed [31:0] centre);
    logic signed [31:0] v;
    case (mix)
      MIX_FULL:    v = $urandom;
      MIX_CLUSTER: v = centre + $signed($urandom_range(32'h0003FFFF) - 32'h0001FFFF);
      MIX_EXTREME: begin
        case ($urandom_range(3))
          0: v = 32'sh7FFFFFFF;
          1: v = 32'sh80000000;
          2: v = 32'sh00000000;
          default: v = 32'shFFFFFFFF;
        endcase
      end
      default:     v = centre;
    endcase
    return v;
  endfunction

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
      failures++;
    end
  endtask

  // receiver: random stall, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        result_stall <= 1'b1;
        repeat (HOLD_OFF) @(posedge clk);
        hold_req = 1'b0;
        result_stall <= 1'b0;
      end else begin
        result_stall <= !calm && ($urandom_range(99) < 11);
      end
    end
  end

  always @(posedge clk) begin
    ci_result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing outstanding, actual mean %h", $time, mean_value);
        failures++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        check_field("interval_low", want.lo, interval_low);
        check_field("interval_high", want.hi, interval_high);
        check_field("mean_value", want.mean, mean_value);
        check_field("std_deviation", 32'(want.sd), 32'(std_deviation));
        check_field("error_margin", 32'(want.margin), 32'(error_margin));
        check_field("bad_level", 32'(want.bad), 32'(bad_level));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d results outstanding", pending_results.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [LEVEL_W-1:0] phase_levels[N_PHASES];
    ci_result_t zero_res;
    ci_result_t none;
    batch_mix_t mix;
    logic signed [31:0] centre;

    phase_levels = '{3'd4, 3'd7, 3'd1, 3'd5, 3'd2, 3'd6, 3'd3, 3'd0, 3'd2};
    zero_res = '0;
    none = '0;
    // all-zero batch at reset level, then a batch swinging between the extremes
    for (int i = 0; i < 2 * BATCH; i++) begin
      stim_table[i].typed = (i == BATCH - 1);
      stim_table[i].res = zero_res;
      if (i < BATCH) stim_table[i].x = '0;
      else stim_table[i].x = (i % 2) ? 32'sh7FFFFFFF : 32'sh80000000;
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (stim_table[i]) send_sample(stim_table[i].x, stim_table[i].typed, stim_table[i].res);
    sample_valid <= 1'b0;

    for (int p = 0; p < N_PHASES; p++) begin
      wait_idle();
      write_level(phase_levels[p]);
      calm = (p == 2);
      if (p == 4) hold_req = 1'b1;
      for (int b = 0; b < BATCHES_PER_PHASE; b++) begin
        mix = batch_mix_t'($urandom_range(3));
        centre = $urandom;
        for (int k = 0; k < BATCH; k++) send_sample(pick_sample(mix, centre), 1'b0, none);
      end
      sample_valid <= 1'b0;
      calm = 1'b0;
    end

    wait_idle();
    $display("Covered %0d samples, %0d results checked, %0d of them at an invalid level",
             samples_sent, results_checked, bad_batches);
    $display("Levels 0 to 7 each set, with one long output hold-off and one idle-free phase");
    if (failures == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: t_confidence_interval.f
hdl/ci_pkg.sv
hdl/ci_div.sv
hdl/ci_sqrt.sv
hdl/t_confidence_interval.sv
dv/tb_t_confidence_interval.sv
